// File: src/tts_pkg.sv
// Shared types and constants of the tick task scheduler.
package tts_pkg;

  // Opcodes of an input item
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_ADD  = 2'd2;

  // Status codes of a result item
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // A run reports at most this many due slots
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned RES_CNT_W    = 4;

  // Largest overrun count a result can carry
  localparam logic [15:0] OVR_REPORT_MAX = 16'hFFFF;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] period;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  task_index;
    logic [15:0] overrun_count;
    logic        dispatched;
    logic        status;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_RUN,
    CMD_ADD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] period;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_RUN_SCAN,
    ST_RUN_EMIT
  } eng_state_t;

endpackage

// File: src/tts_front.sv
// Front stage: accepts input items, drops unused opcodes, holds one decoded command.
module tts_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tts_pkg::in_item_t in_item,
  output logic             push_valid,
  output tts_pkg::cmd_t    push_cmd,
  input  logic             push_full
);
  import tts_pkg::*;

  logic      cmd_valid_r, cmd_valid_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic      accept;
  logic      pushed;
  logic      keep;
  cmd_kind_t kind;

  // Stall only while the held command cannot move into the queue
  assign in_stall   = cmd_valid_r && push_full;
  assign pushed     = cmd_valid_r && !push_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = cmd_valid_r;
  assign push_cmd   = cmd_r;

  // Decode the opcode
  always_comb begin
    keep = 1'b1;
    kind = CMD_TICK;
    case (in_item.opcode)
      OP_TICK: kind = CMD_TICK;
      OP_RUN:  kind = CMD_RUN;
      OP_ADD:  kind = CMD_ADD;
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    cmd_nxt       = cmd_r;
    if (accept && keep) begin
      cmd_valid_nxt = 1'b1;
      cmd_nxt.kind   = kind;
      cmd_nxt.period = in_item.period;
    end else if (pushed) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// File: src/tts_queue.sv
// Short command queue that decouples the front stage from the slot engine.
module tts_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tts_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output tts_pkg::cmd_t pop_cmd,
  input  logic          pop
);
  import tts_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/tts_engine.sv
// Slot engine: slot table memory, tick sweep, dispatch scan and result register.
module tts_engine #(
  parameter int unsigned MAX_SLOTS     = 16,
  parameter int unsigned TICK_WIDTH    = 16,
  parameter int unsigned OVERRUN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tts_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_item
);
  import tts_pkg::*;

  localparam int unsigned SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned MEM_W   = 2 * TICK_WIDTH + OVERRUN_WIDTH;
  localparam int unsigned CNT_LSB = OVERRUN_WIDTH;
  localparam int unsigned PER_LSB = OVERRUN_WIDTH + TICK_WIDTH;
  localparam logic [OVERRUN_WIDTH-1:0] OVR_MAX = {OVERRUN_WIDTH{1'b1}};

  eng_state_t            state_r, state_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [RES_CNT_W-1:0]  n_r, n_nxt;
  logic [MAX_SLOTS-1:0]  due_r, due_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // Slot table: period, counter and overrun count of each slot
  logic [MEM_W-1:0]      slot_mem_r [MAX_SLOTS];
  logic [MEM_W-1:0]      rd_data_r;
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;

  logic                  out_free;
  logic                  load_out;
  out_item_t             res;
  logic [MAX_SLOTS-1:0]  used_mask, above_mask;
  logic                  any_due, more_due;
  logic                  tick_last, run_last;
  logic [TICK_WIDTH-1:0]    rd_per, rd_cnt, cnt_inc, cnt_new;
  logic [OVERRUN_WIDTH-1:0] rd_ovr, ovr_new;
  logic                  hit;
  logic [15:0]           ovr_rep;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Slot masks for the due lookahead
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      used_mask[i]  = (CNT_W'(i) < used_r);
      above_mask[i] = (CNT_W'(i) > CNT_W'(idx_r));
    end
  end

  assign any_due   = |(due_r & used_mask);
  assign more_due  = |(due_r & used_mask & above_mask);
  assign tick_last = ((CNT_W'(idx_r) + CNT_W'(1)) == used_r);
  assign run_last  = (n_r == RES_CNT_W'(RESULT_LIMIT - 1)) || !more_due;

  // Tick update of the slot just read
  always_comb begin
    rd_per  = rd_data_r[PER_LSB +: TICK_WIDTH];
    rd_cnt  = rd_data_r[CNT_LSB +: TICK_WIDTH];
    rd_ovr  = rd_data_r[0 +: OVERRUN_WIDTH];
    cnt_inc = rd_cnt + TICK_WIDTH'(1);
    hit     = (cnt_inc >= rd_per);
    cnt_new = hit ? '0 : cnt_inc;
    ovr_new = rd_ovr;
    if (hit && due_r[idx_r] && (rd_ovr != OVR_MAX)) begin
      ovr_new = rd_ovr + OVERRUN_WIDTH'(1);
    end
    if (32'(rd_ovr) > 32'(OVR_REPORT_MAX)) begin
      ovr_rep = OVR_REPORT_MAX;
    end else begin
      ovr_rep = 16'(rd_ovr);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          case (q_cmd.kind)
            CMD_TICK: if (used_r != '0) state_nxt = ST_TICK_RD;
            CMD_RUN:  if (any_due) state_nxt = ST_RUN_SCAN;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK_RD: state_nxt = ST_TICK_WR;
      ST_TICK_WR: state_nxt = tick_last ? ST_IDLE : ST_TICK_RD;
      ST_RUN_SCAN: begin
        if (due_r[idx_r]) state_nxt = ST_RUN_EMIT;
      end
      ST_RUN_EMIT: begin
        if (out_free) state_nxt = run_last ? ST_IDLE : ST_RUN_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and results
  always_comb begin
    q_pop     = 1'b0;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    n_nxt     = n_r;
    due_nxt   = due_r;
    load_out  = 1'b0;
    res       = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {rd_per, cnt_new, ovr_new};
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          idx_nxt = '0;
          n_nxt   = '0;
          case (q_cmd.kind)
            CMD_ADD: begin
              load_out = 1'b1;
              res.last = 1'b1;
              if (used_r == CNT_W'(MAX_SLOTS)) begin
                res.status = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = used_r[SLOT_W-1:0];
                mem_wdata = {TICK_WIDTH'(q_cmd.period), {TICK_WIDTH{1'b0}},
                             {OVERRUN_WIDTH{1'b0}}};
                due_nxt[used_r[SLOT_W-1:0]] = 1'b0;
                used_nxt       = used_r + CNT_W'(1);
                res.task_index = 4'(used_r);
                res.status     = STATUS_OK;
              end
            end
            CMD_RUN: begin
              // Nothing due: one not-dispatched result
              if (!any_due) begin
                load_out = 1'b1;
                res.last = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_RD: mem_re = 1'b1;
      ST_TICK_WR: begin
        mem_we         = 1'b1;
        due_nxt[idx_r] = due_r[idx_r] | hit;
        idx_nxt        = idx_r + SLOT_W'(1);
      end
      ST_RUN_SCAN: begin
        if (due_r[idx_r]) begin
          mem_re = 1'b1;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_RUN_EMIT: begin
        if (out_free) begin
          load_out          = 1'b1;
          res.task_index    = 4'(idx_r);
          res.overrun_count = ovr_rep;
          res.dispatched    = 1'b1;
          res.status        = STATUS_OK;
          res.last          = run_last;
          due_nxt[idx_r]    = 1'b0;
          n_nxt             = n_r + RES_CNT_W'(1);
          idx_nxt           = idx_r + SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    out_item_nxt  = load_out ? res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      n_r         <= '0;
      due_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      n_r         <= n_nxt;
      due_r       <= due_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  // Slot table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem_r[idx_r];
    end
  end

endmodule

// File: src/tick_task_scheduler_core.sv
// Top level of the tick task scheduler: front stage, command queue and slot engine.
// Usage:
//   Input channel (in_valid, in_stall, in_item) takes tick, run and add items.
//   Result channel (out_valid, out_stall, out_item) gives add acknowledgements
//   and run dispatch results; a tick gives no result, an unused opcode is dropped.
// Path: an accepted item passes the front command register and a queue entry
//   before it reaches the engine; an add or a run with nothing due then shows
//   its result through the result register. An add is handled in the idle state.
//   A tick reads then writes the slot memory for each registered slot. A run
//   scans the slots in order and emits one result per due slot reported, waiting
//   while the receiver stalls; the engine takes its next command only when idle.
// Up to two commands wait in the queue and one in the front stage, so input
//   keeps being accepted while the engine works.
// Reset (rst_n low, synchronous) empties the table, the queue and the result
//   register; no clearing pass is needed afterwards.
// When out_stall is high with a result valid, the result register holds its item
//   and the engine waits before a new command or a run result; the queue then fills and in_stall rises.
module tick_task_scheduler_core #(
  parameter int unsigned MAX_SLOTS     = 16,
  parameter int unsigned TICK_WIDTH    = 16,
  parameter int unsigned OVERRUN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_item
);
  import tts_pkg::*;

  logic push_valid, push_full;
  cmd_t push_cmd;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  tts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_full  (push_full)
  );

  tts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_cmd  (push_cmd),
    .full      (push_full),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd),
    .pop       (q_pop)
  );

  tts_engine #(
    .MAX_SLOTS     (MAX_SLOTS),
    .TICK_WIDTH    (TICK_WIDTH),
    .OVERRUN_WIDTH (OVERRUN_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // A full-table result is a final, non-dispatch result
  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status) |-> (out_item.last && !out_item.dispatched))
    else $error("table-full result not marked last or marked dispatched");

  // Anything that is not a dispatch ends its item
  a_nodisp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.dispatched) |-> out_item.last)
    else $error("non-dispatch result not marked last");

  // Engine only pops a queue that holds a command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");
`endif

endmodule
